// ===== rtl/assert_macros.svh =====
// assertion macros shared by the steering block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wbss_pkg.sv =====
// types, constants and helpers of the white blob side steering block
package wbss_pkg;

    localparam int COL_W   = 12;
    localparam int CNT_W   = 21;
    localparam int WIDTH_W = 13;
    localparam int CMD_W   = 2;

    localparam int MAX_PIXELS = 1048576;
    localparam int CNT_MAX    = (1 << CNT_W) - 1;
    localparam int CAP_INT    = (MAX_PIXELS < CNT_MAX) ? MAX_PIXELS : CNT_MAX;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_INT);

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT = WIDTH_W'(4096);
    localparam logic [7:0]         WHITE       = 8'd255;

    // reciprocal of three scaled by 2^16, exact for operands below 2^14
    localparam logic [15:0] RECIP3 = 16'd21846;

    localparam logic [CMD_W-1:0] STEER_STOP    = 2'd0;
    localparam logic [CMD_W-1:0] STEER_LEFT    = 2'd1;
    localparam logic [CMD_W-1:0] STEER_FORWARD = 2'd2;
    localparam logic [CMD_W-1:0] STEER_RIGHT   = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_frame;
    } pix_t;

    typedef struct packed {
        logic [CMD_W-1:0] steer_cmd;
        logic [CNT_W-1:0] left_total;
        logic [CNT_W-1:0] middle_total;
        logic [CNT_W-1:0] right_total;
    } res_t;

    // column limits derived from the frame width
    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [COL_W-1:0] left_edge;
        logic [COL_W-1:0] mid_edge;
    } bounds_t;

    // frame totals leaving the counters
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] middle;
        logic [CNT_W-1:0] right;
    } tally_t;

    function automatic logic [COL_W-1:0] div3(input logic [WIDTH_W:0] x);
        logic [29:0] prod;
        prod = 30'(x) * 30'(RECIP3);
        return prod[16 +: COL_W];
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c >= COUNT_CAP) ? COUNT_CAP : c + CNT_W'(1);
    endfunction

    function automatic logic [CMD_W-1:0] steer(input logic [CNT_W-1:0] l,
                                               input logic [CNT_W-1:0] m,
                                               input logic [CNT_W-1:0] r);
        logic [CMD_W-1:0] cmd;
        if (l == '0 && m == '0 && r == '0)
            cmd = STEER_STOP;
        else if (l > r && l > m)
            cmd = STEER_LEFT;
        else if (m > l && m > r)
            cmd = STEER_FORWARD;
        else
            cmd = STEER_RIGHT;
        return cmd;
    endfunction

endpackage

// ===== rtl/wbss_bounds.sv =====
// frame width write and the registered third boundaries derived from it
`include "assert_macros.svh"

module wbss_bounds (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [wbss_pkg::WIDTH_W-1:0]  cfg_wr_data,
    output wbss_pkg::bounds_t             bounds
);
    import wbss_pkg::*;

    logic [WIDTH_W-1:0] eff_width;
    bounds_t            bounds_reg;
    bounds_t            bounds_next;

    always_comb
    begin
        if (cfg_wr_data == '0)
            eff_width = WIDTH_W'(1);
        else if (cfg_wr_data > WIDTH_LIMIT)
            eff_width = WIDTH_LIMIT;
        else
            eff_width = cfg_wr_data;

        bounds_next.last_col  = COL_W'(eff_width - WIDTH_W'(1));
        bounds_next.left_edge = div3({1'b0, eff_width});
        bounds_next.mid_edge  = div3({eff_width, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.last_col  <= COL_W'(WIDTH_RESET - WIDTH_W'(1));
            bounds_reg.left_edge <= div3({1'b0, WIDTH_RESET});
            bounds_reg.mid_edge  <= div3({WIDTH_RESET, 1'b0});
        end
        else if (cfg_wr_en)
        begin
            bounds_reg <= bounds_next;
        end
    end

    assign bounds = bounds_reg;

    `ASSERT_ALWAYS(a_edges_ordered,
        bounds_reg.left_edge <= bounds_reg.mid_edge && bounds_reg.mid_edge <= bounds_reg.last_col,
        "third boundaries out of order")

endmodule

// ===== rtl/wbss_tally.sv =====
// column counter and the three white pixel counts
`include "assert_macros.svh"

module wbss_tally (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  wbss_pkg::pix_t    pix,
    input  wbss_pkg::bounds_t bounds,
    output wbss_pkg::tally_t  tally
);
    import wbss_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] right_reg, right_next;
    logic             white;
    logic [CNT_W-1:0] left_upd, mid_upd, right_upd;

    always_comb
    begin
        white = pix.red == WHITE && pix.green == WHITE && pix.blue == WHITE;

        left_upd  = left_reg;
        mid_upd   = mid_reg;
        right_upd = right_reg;
        if (white)
        begin
            if (col_reg <= bounds.left_edge)
                left_upd = bump(left_reg);
            else if (col_reg <= bounds.mid_edge)
                mid_upd = bump(mid_reg);
            else
                right_upd = bump(right_reg);
        end

        col_next   = col_reg;
        left_next  = left_reg;
        mid_next   = mid_reg;
        right_next = right_reg;
        if (advance)
        begin
            if (pix.end_of_frame)
            begin
                col_next   = '0;
                left_next  = '0;
                mid_next   = '0;
                right_next = '0;
            end
            else
            begin
                // a column at or past row end wraps to zero
                col_next   = (col_reg >= bounds.last_col) ? '0 : col_reg + COL_W'(1);
                left_next  = left_upd;
                mid_next   = mid_upd;
                right_next = right_upd;
            end
        end

        tally.done   = advance && pix.end_of_frame;
        tally.left   = left_upd;
        tally.middle = mid_upd;
        tally.right  = right_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            left_reg  <= '0;
            mid_reg   <= '0;
            right_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            left_reg  <= left_next;
            mid_reg   <= mid_next;
            right_reg <= right_next;
        end
    end

    `ASSERT_ALWAYS(a_counts_capped,
        left_reg <= COUNT_CAP && mid_reg <= COUNT_CAP && right_reg <= COUNT_CAP,
        "white count above saturation cap")

    `ASSERT_NEXT(a_frame_clears, tally.done,
        col_reg == '0 && left_reg == '0 && mid_reg == '0 && right_reg == '0,
        "counters not cleared after frame end")

endmodule

// ===== rtl/wbss_result.sv =====
// result register and steering decision
module wbss_result (
    input  logic             clk,
    input  logic             rst_n,
    input  wbss_pkg::tally_t tally,
    input  logic             res_stall,
    output logic             res_valid,
    output wbss_pkg::res_t   res
);
    import wbss_pkg::*;

    logic             vld_reg, vld_next;
    logic [CNT_W-1:0] left_reg, mid_reg, right_reg;

    always_comb
    begin
        if (tally.done)
            vld_next = 1'b1;
        else
            vld_next = vld_reg && res_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (tally.done)
        begin
            left_reg  <= tally.left;
            mid_reg   <= tally.middle;
            right_reg <= tally.right;
        end
    end

    assign res_valid        = vld_reg;
    assign res.steer_cmd    = steer(left_reg, mid_reg, right_reg);
    assign res.left_total   = left_reg;
    assign res.middle_total = mid_reg;
    assign res.right_total  = right_reg;

endmodule

// ===== rtl/white_blob_side_steering.sv =====
// White blob side steering: counts pure white pixels (all channels 255) of a raster-order
// RGB stream in the left, middle and right thirds of each row and, on the beat marked
// end_of_frame, returns one steering result with the three saturating counts. A pixel
// beat is taken every cycle unless stalled; the column and count update for one pixel
// is a single register-to-register step, so the sustained rate is one pixel per clock
// between stalls. The only back-pressure is a frame end meeting a result that is still
// stalled. frame_width is written while the stream is idle; this binds the user, as the
// block does not enforce it. The third boundaries are computed at the write.
`include "assert_macros.svh"

module white_blob_side_steering (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [wbss_pkg::WIDTH_W-1:0] cfg_wr_data,
    input  logic                         pix_valid,
    output logic                         pix_stall,
    input  wbss_pkg::pix_t               pix,
    output logic                         res_valid,
    input  logic                         res_stall,
    output wbss_pkg::res_t               res
);
    import wbss_pkg::*;

    pix_t    pix_reg;
    logic    pix_vld_reg, pix_vld_next;
    logic    advance;
    logic    load;
    bounds_t bounds;
    tally_t  tally;

    // a frame end waits while the previous result is still held
    assign advance   = pix_vld_reg && !(pix_reg.end_of_frame && res_valid && res_stall);
    assign pix_stall = pix_vld_reg && !advance;
    assign load      = pix_valid && !pix_stall;

    always_comb
    begin
        if (load)
            pix_vld_next = 1'b1;
        else if (advance)
            pix_vld_next = 1'b0;
        else
            pix_vld_next = pix_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_vld_reg <= 1'b0;
        else
            pix_vld_reg <= pix_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pix_reg <= pix;
    end

    wbss_bounds u_bounds (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .bounds      (bounds)
    );

    wbss_tally u_tally (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pix     (pix_reg),
        .bounds  (bounds),
        .tally   (tally)
    );

    wbss_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .tally     (tally),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res)
    );

    `ASSERT_NEXT(a_frame_end_result, tally.done, res_valid,
        "frame end beat gave no result")

endmodule

// ===== tb/sv/tb_white_blob_side_steering.sv =====
// self-checking testbench of the white blob side steering block
`timescale 1ns / 100ps

module tb_white_blob_side_steering;
    import wbss_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int SETTLE       = 4;
    localparam int PHASES       = 12;
    localparam int PHASE_BEATS  = 120;

    // predicts frame results from accepted pixels and checks them in order
    class steer_scoreboard;
        logic [WIDTH_W-1:0] width_reg;
        logic [COL_W-1:0]   col;
        logic [CNT_W-1:0]   left_n;
        logic [CNT_W-1:0]   mid_n;
        logic [CNT_W-1:0]   right_n;
        res_t               frame_results[$];
        int                 errors;

        function new();
            width_reg = WIDTH_RESET;
            col       = '0;
            left_n    = '0;
            mid_n     = '0;
            right_n   = '0;
            errors    = 0;
        endfunction

        function void set_width(logic [WIDTH_W-1:0] w);
            width_reg = w;
        endfunction

        function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
            return (c >= COUNT_CAP) ? COUNT_CAP : c + CNT_W'(1);
        endfunction

        function void note_pixel(pix_t p);
            int unsigned w;
            int unsigned c;
            res_t        r;
            w = 32'(width_reg);
            if (w == 0)
                w = 1;
            if (w > 4096)
                w = 4096;
            c = 32'(col);
            if (p.red == WHITE && p.green == WHITE && p.blue == WHITE)
            begin
                if (c <= w / 3)
                    left_n = sat_inc(left_n);
                else if (c <= (2 * w) / 3)
                    mid_n = sat_inc(mid_n);
                else
                    right_n = sat_inc(right_n);
            end
            // a column at or past the row end wraps to zero
            if (c >= w - 1)
                col = '0;
            else
                col = COL_W'(c + 1);
            if (p.end_of_frame)
            begin
                r.left_total   = left_n;
                r.middle_total = mid_n;
                r.right_total  = right_n;
                if (left_n == 0 && mid_n == 0 && right_n == 0)
                    r.steer_cmd = STEER_STOP;
                else if (left_n > right_n && left_n > mid_n)
                    r.steer_cmd = STEER_LEFT;
                else if (mid_n > left_n && mid_n > right_n)
                    r.steer_cmd = STEER_FORWARD;
                else
                    r.steer_cmd = STEER_RIGHT;
                frame_results.push_back(r);
                col     = '0;
                left_n  = '0;
                mid_n   = '0;
                right_n = '0;
            end
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (frame_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no frame open, expected none, actual %0d %0d %0d %0d",
                         $time, got.steer_cmd, got.left_total, got.middle_total,
                         got.right_total);
                return;
            end
            want = frame_results.pop_front();
            if (got.steer_cmd !== want.steer_cmd)
                report("steer_cmd", want.steer_cmd, got.steer_cmd);
            if (got.left_total !== want.left_total)
                report("left_total", want.left_total, got.left_total);
            if (got.middle_total !== want.middle_total)
                report("middle_total", want.middle_total, got.middle_total);
            if (got.right_total !== want.right_total)
                report("right_total", want.right_total, got.right_total);
        endfunction

        function int pending();
            return frame_results.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [WIDTH_W-1:0] cfg_wr_data = '0;
    logic               pix_valid = 1'b0;
    logic               pix_stall;
    pix_t               pix = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    res_t               res;

    int          sender_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count = 0;

    steer_scoreboard board = new();

    white_blob_side_steering u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pix         (pix),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_white_blob_side_steering: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // pixel beats are noted before results so a frame is open when its result lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
                board.note_pixel(pix);
            if (res_valid && !res_stall)
                board.check_result(res);
        end
    end

    task automatic send_beat(input pix_t p);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix       <= p;
        pix_valid <= 1'b1;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic eof);
        pix_t p;
        p.red          = r;
        p.green        = g;
        p.blue         = b;
        p.end_of_frame = eof;
        send_beat(p);
    endtask

    // stop sending and wait for every open frame result
    task automatic wait_results();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        wait_results();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        board.set_width(w);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    function automatic pix_t make_pixel(input int white_pct, input logic eof);
        pix_t p;
        int   kind;
        kind           = $urandom_range(0, 99);
        p.red          = 8'($urandom_range(0, 255));
        p.green        = 8'($urandom_range(0, 255));
        p.blue         = 8'($urandom_range(0, 255));
        p.end_of_frame = eof;
        if (kind < white_pct)
        begin
            p.red   = WHITE;
            p.green = WHITE;
            p.blue  = WHITE;
        end
        else if (kind < white_pct + (100 - white_pct) / 2)
        begin
            // near white: one channel short of full scale
            p.red   = WHITE;
            p.green = WHITE;
            p.blue  = WHITE;
            case ($urandom_range(0, 2))
                0: p.red   = 8'($urandom_range(0, 254));
                1: p.green = 8'($urandom_range(0, 254));
                default: p.blue = 8'($urandom_range(0, 254));
            endcase
        end
        return p;
    endfunction

    function automatic logic [WIDTH_W-1:0] phase_width(input int ph);
        case (ph)
            0: return WIDTH_W'(1);
            1: return WIDTH_W'(2);
            2: return WIDTH_W'(3);
            3: return WIDTH_W'(4096);
            4: return WIDTH_W'(5);
            5: return WIDTH_W'(8191);
            6: return WIDTH_W'(6);
            7: return WIDTH_W'(0);
            8: return WIDTH_W'(9);
            9: return WIDTH_W'($urandom_range(1, 8191));
            10: return WIDTH_W'(7);
            default: return WIDTH_W'($urandom_range(4097, 8191));
        endcase
    endfunction

    initial
    begin
        int white_pct;
        int eof_pct;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width: lone white pixel, then an empty frame
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);

        // width 4: cols 0,1 left, col 2 middle, col 3 right
        write_width(WIDTH_W'(4));
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        // left and right tie
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'hFE, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFE, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b1);

        // zero width behaves as one
        write_width(WIDTH_W'(0));
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

        // oversize width clamps, frame left open across the next write
        write_width(WIDTH_W'(8191));
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        // narrowing mid frame puts the column past the row end
        write_width(WIDTH_W'(2));
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_width(phase_width(ph));
            set_idling(ph % 4);
            white_pct = $urandom_range(20, 90);
            eof_pct   = $urandom_range(3, 20);
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                // sender holds off until all open results are back
                if (i == PHASE_BEATS / 2 && ph % 3 == 1)
                    wait_results();
                send_beat(make_pixel(white_pct, $urandom_range(0, 99) < eof_pct));
            end
        end

        set_idling(3);
        wait_results();
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_white_blob_side_steering: PASS");
        else
            $display("tb_white_blob_side_steering: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wbss_pkg.sv
rtl/wbss_bounds.sv
rtl/wbss_tally.sv
rtl/wbss_result.sv
rtl/white_blob_side_steering.sv
tb/sv/tb_white_blob_side_steering.sv
